// ----- sv/assert_macros.svh -----
// Assertion macros shared by the strided tensor store RTL.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition and property in the same cycle.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Property in the cycle after the condition.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- sv/sts_pkg.sv -----
// Package for the strided tensor store: field widths, register indexes,
// payload and geometry structs, and the controller state type. No dependencies.
package sts_pkg;

    localparam int REG_DIMS   = 4;
    localparam int MAX_DIMS   = 4;
    localparam int DIM_SEL_W  = 2;
    localparam int IDX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int NDIM_W     = 3;
    localparam int STRIDE_W   = 24;
    localparam int VAL_W      = 64;
    localparam int OFFS_W     = 38;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [STRIDE_W-1:0] STRIDE_MAX = {STRIDE_W{1'b1}};

    // Effective upper bound on the active dimension count.
    localparam int DIM_LIMIT = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAJOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_C = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_D = 3'd5;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic [IDX_W-1:0] index_c;
        logic [IDX_W-1:0] index_d;
        logic [VAL_W-1:0] write_value;
    } access_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             out_of_bounds;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

    // Array geometry handed from the stride unit to the access controller.
    typedef struct packed {
        logic [NDIM_W-1:0]                  active_dims;
        logic [REG_DIMS-1:0][DIM_W-1:0]     dim_size;
        logic [REG_DIMS-1:0][STRIDE_W-1:0]  stride;
        logic                               busy;
    } geo_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_ACCESS,
        ST_REPLY
    } sts_state_t;

endpackage

// ----- sv/sts_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// The payload type is set per instance; no package dependency.
interface sts_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/sts_stride_unit.sv -----
// Configuration registers and stride sequencer of the strided tensor store.
// Depends on sts_pkg and sts_stream_if.
module sts_stride_unit (
    input  logic              clk,
    input  logic              rst_n,
    sts_stream_if.sink        cfg,
    output sts_pkg::geo_t     geo
);

    logic [sts_pkg::NDIM_W-1:0]                         num_dims_reg;
    logic                                               row_major_reg;
    logic [sts_pkg::REG_DIMS-1:0][sts_pkg::DIM_W-1:0]   dim_size_reg;
    logic [sts_pkg::REG_DIMS-1:0][sts_pkg::STRIDE_W-1:0] stride_reg;
    logic                                               busy_reg;
    logic [sts_pkg::DIM_SEL_W-1:0]                      step_reg;
    logic [sts_pkg::STRIDE_W-1:0]                       run_reg;

    logic                                cfg_wr;
    logic                                cfg_hit;
    logic [sts_pkg::NDIM_W-1:0]          active_dims;
    logic [sts_pkg::NDIM_W-1:0]          last_step;
    logic [sts_pkg::DIM_SEL_W-1:0]       pos;
    logic [sts_pkg::STRIDE_W+sts_pkg::DIM_W-1:0] run_prod;
    logic [sts_pkg::STRIDE_W-1:0]        run_next;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // A write to any known register restarts the stride computation.
    always_comb
    begin
        unique case (cfg.payload.index) inside
            sts_pkg::CFG_NUM_DIMS, sts_pkg::CFG_ROW_MAJOR,
            sts_pkg::CFG_DIM_SIZE_A, sts_pkg::CFG_DIM_SIZE_B,
            sts_pkg::CFG_DIM_SIZE_C, sts_pkg::CFG_DIM_SIZE_D: cfg_hit = 1'b1;
            default:                                          cfg_hit = 1'b0;
        endcase
    end

    // Active dimension count: zero counts as one, large values saturate.
    always_comb
    begin
        if (num_dims_reg == '0)
            active_dims = sts_pkg::NDIM_W'(1);
        else if (num_dims_reg > sts_pkg::NDIM_W'(sts_pkg::DIM_LIMIT))
            active_dims = sts_pkg::NDIM_W'(sts_pkg::DIM_LIMIT);
        else
            active_dims = num_dims_reg;
    end

    // Row-major walks from the last active dimension down, column-major from the first up.
    always_comb
    begin
        last_step = active_dims - sts_pkg::NDIM_W'(1);
        if (row_major_reg)
            pos = sts_pkg::DIM_SEL_W'(last_step - {1'b0, step_reg});
        else
            pos = step_reg;
        run_prod = run_reg * dim_size_reg[pos];
        if (run_prod > (sts_pkg::STRIDE_W+sts_pkg::DIM_W)'(sts_pkg::STRIDE_MAX))
            run_next = sts_pkg::STRIDE_MAX;
        else
            run_next = run_prod[sts_pkg::STRIDE_W-1:0];
    end

    // Register file and one saturating multiply per cycle of the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg  <= sts_pkg::NDIM_W'(1);
            row_major_reg <= 1'b1;
            dim_size_reg  <= {sts_pkg::REG_DIMS{sts_pkg::DIM_W'(1)}};
            stride_reg    <= {{(sts_pkg::REG_DIMS-1){sts_pkg::STRIDE_W'(0)}},
                              sts_pkg::STRIDE_W'(1)};
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            run_reg       <= sts_pkg::STRIDE_W'(1);
        end
        else if (cfg_wr && cfg_hit)
        begin
            unique case (cfg.payload.index)
                sts_pkg::CFG_NUM_DIMS:
                    num_dims_reg <= cfg.payload.value[sts_pkg::NDIM_W-1:0];
                sts_pkg::CFG_ROW_MAJOR:
                    row_major_reg <= cfg.payload.value[0];
                sts_pkg::CFG_DIM_SIZE_A:
                    dim_size_reg[0] <= cfg.payload.value[sts_pkg::DIM_W-1:0];
                sts_pkg::CFG_DIM_SIZE_B:
                    dim_size_reg[1] <= cfg.payload.value[sts_pkg::DIM_W-1:0];
                sts_pkg::CFG_DIM_SIZE_C:
                    dim_size_reg[2] <= cfg.payload.value[sts_pkg::DIM_W-1:0];
                default:
                    dim_size_reg[3] <= cfg.payload.value[sts_pkg::DIM_W-1:0];
            endcase
            stride_reg <= '0;
            busy_reg   <= 1'b1;
            step_reg   <= '0;
            run_reg    <= sts_pkg::STRIDE_W'(1);
        end
        else if (busy_reg)
        begin
            stride_reg[pos] <= run_reg;
            run_reg         <= run_next;
            step_reg        <= step_reg + sts_pkg::DIM_SEL_W'(1);
            if ({1'b0, step_reg} == last_step)
                busy_reg <= 1'b0;
        end
    end

    assign geo.active_dims = active_dims;
    assign geo.dim_size    = dim_size_reg;
    assign geo.stride      = stride_reg;
    assign geo.busy        = busy_reg;

endmodule

// ----- sv/strided_tensor_store_top.sv -----
// Top level of the strided tensor store: element memory and access controller.
// Depends on sts_pkg, sts_stream_if, sts_stride_unit and assert_macros.svh.
//
// The store holds STORE_DEPTH 64-bit elements in one single-port synchronous RAM
// addressed by a strided linear offset. After reset the RAM is zeroed by a clearing
// pass over every address, during which no access is accepted; configuration
// writes are taken throughout. A write to a known register restarts the stride
// computation, one saturating multiply per cycle for each active dimension, and
// accesses wait until it ends. For each access, a shared multiply-accumulate walks
// the active dimensions one per cycle, then the ACCESS state issues the RAM access
// and the REPLY state brings the registered read data into the result register. A
// result waiting in the output register holds the next reply back, and with it the
// next acceptance, since the controller stays in REPLY until it can load.
`include "assert_macros.svh"

module strided_tensor_store_top #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    sts_stream_if.sink    access,
    sts_stream_if.source  result,
    sts_stream_if.sink    cfg
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [sts_pkg::OFFS_W-1:0] DEPTH_OFFS = sts_pkg::OFFS_W'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
    localparam int PROD_W = sts_pkg::IDX_W + sts_pkg::STRIDE_W;

    sts_pkg::geo_t       geo;
    sts_pkg::sts_state_t state_reg, state_next;
    sts_pkg::access_t    item_reg;
    sts_pkg::result_t    out_reg;

    logic [AW-1:0]                   clear_cnt_reg;
    logic [sts_pkg::DIM_SEL_W-1:0]   dim_cnt_reg;
    logic [sts_pkg::OFFS_W-1:0]      acc_reg;
    logic                            oob_reg;
    logic                            rd_en_reg;
    logic                            out_valid_reg;
    logic [sts_pkg::VAL_W-1:0]       rdata_reg;

    logic [sts_pkg::VAL_W-1:0]       mem [STORE_DEPTH];

    logic                                              in_fire;
    logic [sts_pkg::REG_DIMS-1:0][sts_pkg::IDX_W-1:0]  idx_vec;
    logic [sts_pkg::IDX_W-1:0]                         idx_sel;
    logic [PROD_W-1:0]                                 mac_prod;
    logic [sts_pkg::OFFS_W-1:0]                        acc_next;
    logic                                              idx_oob;
    logic                                              mac_last;
    logic                                              oob_final;
    logic                                              mem_we;
    logic                                              mem_re;
    logic [AW-1:0]                                     mem_addr;
    logic [sts_pkg::VAL_W-1:0]                         mem_wdata;
    logic                                              out_load;

    sts_stride_unit u_stride (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .geo   (geo)
    );

    assign in_fire = access.valid && access.ready;

    // Multiply-accumulate over one dimension per cycle, with its bound check.
    always_comb
    begin
        idx_vec  = {item_reg.index_d, item_reg.index_c, item_reg.index_b, item_reg.index_a};
        idx_sel  = idx_vec[dim_cnt_reg];
        mac_prod = idx_sel * geo.stride[dim_cnt_reg];
        acc_next = acc_reg + sts_pkg::OFFS_W'(mac_prod);
        idx_oob  = {1'b0, idx_sel} >= geo.dim_size[dim_cnt_reg];
        mac_last = {1'b0, dim_cnt_reg} == (geo.active_dims - sts_pkg::NDIM_W'(1));
        oob_final = oob_reg || (acc_reg >= DEPTH_OFFS);
    end

    // Controller next state and RAM port control.
    always_comb
    begin
        state_next    = state_reg;
        access.ready  = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = acc_reg[AW-1:0];
        mem_wdata     = item_reg.write_value;
        out_load      = 1'b0;
        unique case (state_reg)
            sts_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clear_cnt_reg;
                mem_wdata = '0;
                if (clear_cnt_reg == LAST_ADDR)
                    state_next = sts_pkg::ST_IDLE;
            end
            sts_pkg::ST_IDLE:
            begin
                access.ready = !geo.busy;
                if (in_fire)
                    state_next = sts_pkg::ST_MAC;
            end
            sts_pkg::ST_MAC:
            begin
                if (mac_last)
                    state_next = sts_pkg::ST_ACCESS;
            end
            sts_pkg::ST_ACCESS:
            begin
                mem_we     = !oob_final && (item_reg.kind == sts_pkg::KIND_WRITE);
                mem_re     = !oob_final && (item_reg.kind == sts_pkg::KIND_READ);
                state_next = sts_pkg::ST_REPLY;
            end
            sts_pkg::ST_REPLY:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = sts_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sts_pkg::ST_IDLE;
        endcase
    end

    // Controller state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sts_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
            dim_cnt_reg   <= '0;
            acc_reg       <= '0;
            oob_reg       <= 1'b0;
            rd_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sts_pkg::ST_CLEAR)
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            if (in_fire)
            begin
                dim_cnt_reg <= '0;
                acc_reg     <= '0;
                oob_reg     <= 1'b0;
            end
            else if (state_reg == sts_pkg::ST_MAC)
            begin
                dim_cnt_reg <= dim_cnt_reg + sts_pkg::DIM_SEL_W'(1);
                acc_reg     <= acc_next;
                oob_reg     <= oob_reg || idx_oob;
            end
            else if (state_reg == sts_pkg::ST_ACCESS)
            begin
                oob_reg   <= oob_final;
                rd_en_reg <= mem_re;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Accepted item and result register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= access.payload;
        if (out_load)
        begin
            out_reg.read_value    <= rd_en_reg ? rdata_reg : '0;
            out_reg.out_of_bounds <= oob_reg;
        end
    end

    // Element RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_addr];
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    `ASSERT_NEXT(a_accept_starts_walk, in_fire, state_reg == sts_pkg::ST_MAC && acc_reg == '0, "accepted access did not start the offset walk")
    `ASSERT_IMPLIES(a_oob_reads_zero, result.valid && result.payload.out_of_bounds, result.payload.read_value == '0, "out-of-bounds result carries data")
    `ASSERT_IMPLIES(a_write_in_range, mem_we && state_reg != sts_pkg::ST_CLEAR, acc_reg < DEPTH_OFFS && item_reg.kind == sts_pkg::KIND_WRITE, "RAM write outside an in-range write access")

endmodule

// ----- dv/strided_tensor_store_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for strided_tensor_store_top: it programs array geometries,
// drives element accesses and checks every result against an internal mirror of the store.
// Depends on sts_pkg, sts_stream_if and the strided tensor store RTL.
module strided_tensor_store_top_tb;

    localparam int STORE_DEPTH = 4096;

    // Register indexes past the last geometry register; writes to them are ignored.
    localparam logic [sts_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [sts_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    sts_stream_if #(.payload_t(sts_pkg::access_t)) access_if ();
    sts_stream_if #(.payload_t(sts_pkg::result_t)) result_if ();
    sts_stream_if #(.payload_t(sts_pkg::cfg_t))    cfg_if ();

    strided_tensor_store_top #(
        .STORE_DEPTH (STORE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Mirror of the element store, the geometry registers and the stride table.
    logic [sts_pkg::VAL_W-1:0]    element_mirror [STORE_DEPTH];
    logic [sts_pkg::NDIM_W-1:0]   num_dims_reg;
    logic                         row_major_reg;
    logic [sts_pkg::DIM_W-1:0]    dim_size_reg [sts_pkg::REG_DIMS];
    logic [sts_pkg::STRIDE_W-1:0] stride_mirror [sts_pkg::REG_DIMS];

    sts_pkg::access_t pending_accesses [$];
    sts_pkg::result_t element_replies_due [$];
    sts_pkg::result_t due_reply;

    int unsigned accesses_queued = 0;
    int unsigned accesses_taken  = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned oob_seen        = 0;
    int unsigned nonzero_reads   = 0;
    int unsigned geometry_phases = 0;
    int unsigned err_count       = 0;
    int unsigned send_gap        = 0;
    int unsigned recv_stall      = 0;
    logic        access_fired    = 1'b0;
    logic        result_fired    = 1'b0;
    bit          back_to_back    = 1'b0;

    // Geometry the stimulus is currently shaped for.
    int unsigned      plan_dims;
    int unsigned      plan_size [sts_pkg::REG_DIMS];
    sts_pkg::access_t written_items [$];

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_dim_count();
        int unsigned n;
        n = 32'(num_dims_reg);
        if (n < 1)
            n = 1;
        if (n > sts_pkg::DIM_LIMIT)
            n = sts_pkg::DIM_LIMIT;
        return n;
    endfunction

    function automatic logic [sts_pkg::STRIDE_W-1:0] saturating_stride(
        input logic [sts_pkg::STRIDE_W-1:0] s,
        input logic [sts_pkg::DIM_W-1:0]    d);
        logic [sts_pkg::STRIDE_W+sts_pkg::DIM_W-1:0] prod;
        prod = s * d;
        return (prod > sts_pkg::STRIDE_MAX) ? sts_pkg::STRIDE_MAX
                                            : prod[sts_pkg::STRIDE_W-1:0];
    endfunction

    // Strides follow the storage order: the innermost active dimension has stride one.
    function automatic void refresh_strides();
        int unsigned n;
        int unsigned i;
        n = active_dim_count();
        for (i = 0; i < sts_pkg::REG_DIMS; i++)
            stride_mirror[i] = '0;
        if (row_major_reg)
        begin
            stride_mirror[n - 1] = sts_pkg::STRIDE_W'(1);
            for (i = n - 1; i > 0; i--)
                stride_mirror[i - 1] = saturating_stride(stride_mirror[i], dim_size_reg[i]);
        end
        else
        begin
            stride_mirror[0] = sts_pkg::STRIDE_W'(1);
            for (i = 1; i < n; i++)
                stride_mirror[i] = saturating_stride(stride_mirror[i - 1], dim_size_reg[i - 1]);
        end
    endfunction

    // Works out the result of one access and applies a write to the mirror.
    function automatic sts_pkg::result_t predict_element_access(input sts_pkg::access_t acc);
        logic [sts_pkg::IDX_W-1:0] idx [sts_pkg::REG_DIMS];
        logic [63:0]               offset;
        logic                      oob;
        int unsigned               n;
        int unsigned               i;
        sts_pkg::result_t          res;
        idx[0] = acc.index_a;
        idx[1] = acc.index_b;
        idx[2] = acc.index_c;
        idx[3] = acc.index_d;
        n = active_dim_count();
        oob = 1'b0;
        offset = '0;
        for (i = 0; i < n; i++)
        begin
            if ({1'b0, idx[i]} >= dim_size_reg[i])
                oob = 1'b1;
            offset += 64'(idx[i]) * 64'(stride_mirror[i]);
        end
        if (offset >= STORE_DEPTH)
            oob = 1'b1;
        res.read_value = '0;
        res.out_of_bounds = oob;
        if (!oob)
        begin
            if (acc.kind == sts_pkg::KIND_WRITE)
                element_mirror[int'(offset)] = acc.write_value;
            else
                res.read_value = element_mirror[int'(offset)];
        end
        return res;
    endfunction

    // Monitor: mirror reset, register writes, accepted accesses and returned results.
    always @(posedge clk)
    begin
        access_fired <= access_if.valid && access_if.ready;
        result_fired <= result_if.valid && result_if.ready;
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_DEPTH; k++)
                element_mirror[k] = '0;
            num_dims_reg  = sts_pkg::NDIM_W'(1);
            row_major_reg = 1'b1;
            for (int k = 0; k < sts_pkg::REG_DIMS; k++)
                dim_size_reg[k] = sts_pkg::DIM_W'(1);
            refresh_strides();
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.payload.index)
                    sts_pkg::CFG_NUM_DIMS:
                        num_dims_reg = cfg_if.payload.value[sts_pkg::NDIM_W-1:0];
                    sts_pkg::CFG_ROW_MAJOR:  row_major_reg   = cfg_if.payload.value[0];
                    sts_pkg::CFG_DIM_SIZE_A: dim_size_reg[0] = cfg_if.payload.value;
                    sts_pkg::CFG_DIM_SIZE_B: dim_size_reg[1] = cfg_if.payload.value;
                    sts_pkg::CFG_DIM_SIZE_C: dim_size_reg[2] = cfg_if.payload.value;
                    sts_pkg::CFG_DIM_SIZE_D: dim_size_reg[3] = cfg_if.payload.value;
                    default: ;
                endcase
                if (cfg_if.payload.index <= sts_pkg::CFG_DIM_SIZE_D)
                    refresh_strides();
                reg_writes++;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (element_replies_due.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: read_value %h out_of_bounds %b",
                             $time, result_if.payload.read_value,
                             result_if.payload.out_of_bounds);
                    err_count++;
                end
                else
                begin
                    due_reply = element_replies_due.pop_front();
                    if (result_if.payload.read_value !== due_reply.read_value)
                    begin
                        $display("%0t: read_value mismatch: expected %h, actual %h", $time,
                                 due_reply.read_value, result_if.payload.read_value);
                        err_count++;
                    end
                    if (result_if.payload.out_of_bounds !== due_reply.out_of_bounds)
                    begin
                        $display("%0t: out_of_bounds mismatch: expected %b, actual %b", $time,
                                 due_reply.out_of_bounds, result_if.payload.out_of_bounds);
                        err_count++;
                    end
                    if (result_if.payload.read_value != '0)
                        nonzero_reads++;
                    results_checked++;
                end
            end
            if (access_if.valid && access_if.ready)
            begin
                due_reply = predict_element_access(access_if.payload);
                if (due_reply.out_of_bounds)
                    oob_seen++;
                element_replies_due.push_back(due_reply);
                accesses_taken++;
            end
        end
    end

    // Access driver: presents queued transactions with a random gap after each one.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            access_if.valid   <= 1'b0;
            access_if.payload <= '0;
        end
        else if (!access_if.valid || access_fired)
        begin
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                access_if.valid <= 1'b0;
            end
            else if (pending_accesses.size() != 0)
            begin
                access_if.payload <= pending_accesses.pop_front();
                access_if.valid   <= 1'b1;
                send_gap = back_to_back ? 0 : $urandom_range(0, 19);
            end
            else
            begin
                access_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls for a random number of cycles after each transaction.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_fired)
                recv_stall = back_to_back ? 0 : $urandom_range(0, 19);
            if (recv_stall != 0)
            begin
                recv_stall = recv_stall - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic queue_access(input sts_pkg::access_t acc);
        pending_accesses.push_back(acc);
        accesses_queued++;
    endtask

    // Lets every queued access complete, then a few cycles more so the block is idle.
    task automatic wait_replies_done();
        while (accesses_taken != accesses_queued || element_replies_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sts_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.payload <= '{index: idx, value: data};
        cfg_if.valid   <= 1'b1;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    endtask

    // Writes all six geometry registers; unused upper bits of the narrow ones are random.
    task automatic program_geometry(input logic [sts_pkg::NDIM_W-1:0] raw_dims,
                                    input logic row,
                                    input logic [sts_pkg::DIM_W-1:0] size_a,
                                    input logic [sts_pkg::DIM_W-1:0] size_b,
                                    input logic [sts_pkg::DIM_W-1:0] size_c,
                                    input logic [sts_pkg::DIM_W-1:0] size_d,
                                    input bit with_spare);
        if (with_spare)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 13'($urandom));
        write_reg(sts_pkg::CFG_NUM_DIMS, {10'($urandom), raw_dims});
        write_reg(sts_pkg::CFG_ROW_MAJOR, {12'($urandom), row});
        write_reg(sts_pkg::CFG_DIM_SIZE_A, size_a);
        write_reg(sts_pkg::CFG_DIM_SIZE_B, size_b);
        write_reg(sts_pkg::CFG_DIM_SIZE_C, size_c);
        write_reg(sts_pkg::CFG_DIM_SIZE_D, size_d);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        plan_dims = (raw_dims == 0) ? 1 :
                    (raw_dims > sts_pkg::DIM_LIMIT) ? sts_pkg::DIM_LIMIT : 32'(raw_dims);
        plan_size[0] = 32'(size_a);
        plan_size[1] = 32'(size_b);
        plan_size[2] = 32'(size_c);
        plan_size[3] = 32'(size_d);
        geometry_phases++;
    endtask

    // An index inside the dimension, leaning toward its last entry; any index for size zero.
    function automatic logic [sts_pkg::IDX_W-1:0] pick_index(input int unsigned size);
        int unsigned lim;
        if (size == 0)
            return sts_pkg::IDX_W'($urandom);
        lim = (size > (1 << sts_pkg::IDX_W)) ? (1 << sts_pkg::IDX_W) : size;
        if ($urandom_range(0, 4) == 0)
            return sts_pkg::IDX_W'(lim - 1);
        return sts_pkg::IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // Mostly in-bounds writes and reads of earlier writes, plus raw noise.
    task automatic queue_random_phase(input int unsigned count);
        sts_pkg::access_t acc;
        sts_pkg::access_t prior;
        int unsigned      roll;
        written_items.delete();
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            acc.kind        = $urandom_range(0, 1) ? sts_pkg::KIND_WRITE : sts_pkg::KIND_READ;
            acc.index_a     = sts_pkg::IDX_W'($urandom);
            acc.index_b     = sts_pkg::IDX_W'($urandom);
            acc.index_c     = sts_pkg::IDX_W'($urandom);
            acc.index_d     = sts_pkg::IDX_W'($urandom);
            acc.write_value = {$urandom, $urandom};
            if (roll < 88)
            begin
                acc.index_a = pick_index(plan_size[0]);
                if (plan_dims > 1)
                    acc.index_b = pick_index(plan_size[1]);
                if (plan_dims > 2)
                    acc.index_c = pick_index(plan_size[2]);
                if (plan_dims > 3)
                    acc.index_d = pick_index(plan_size[3]);
                acc.kind = (roll < 40) ? sts_pkg::KIND_WRITE : sts_pkg::KIND_READ;
                if (roll >= 40 && roll < 75 && written_items.size() != 0)
                begin
                    prior = written_items[$urandom_range(0, written_items.size() - 1)];
                    acc.index_a = prior.index_a;
                    acc.index_b = prior.index_b;
                    acc.index_c = prior.index_c;
                    acc.index_d = prior.index_d;
                end
                if (acc.kind == sts_pkg::KIND_WRITE)
                    written_items.push_back(acc);
            end
            queue_access(acc);
        end
    endtask

    // Main sequence: reset, directed geometries, random geometries, then the verdict.
    initial
    begin : stimulus
        logic [sts_pkg::NDIM_W-1:0] raw_dims;
        logic [sts_pkg::DIM_W-1:0]  sizes [sts_pkg::REG_DIMS];
        int unsigned                n;
        int unsigned                cap;
        int unsigned                roll;
        int unsigned                phase;
        int unsigned                i;

        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        rst_n          = 1'b0;
        plan_dims = 1;
        for (i = 0; i < sts_pkg::REG_DIMS; i++)
            plan_size[i] = 1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry: one dimension of size one; inactive indices are ignored.
        queue_access('{sts_pkg::KIND_READ,  12'd0,    12'd4095, 12'd4095, 12'd4095, 64'd0});
        queue_access('{sts_pkg::KIND_WRITE, 12'd0,    12'd4095, 12'd4095, 12'd4095, '1});
        queue_access('{sts_pkg::KIND_READ,  12'd0,    12'd0,    12'd0,    12'd0,    64'd0});
        queue_access('{sts_pkg::KIND_READ,  12'd4095, 12'd0,    12'd0,    12'd0,    64'd0});
        queue_access('{sts_pkg::KIND_WRITE, 12'd1,    12'd0,    12'd0,    12'd0,    64'h1234});
        wait_replies_done();

        // Dimension count above the limit saturates to four; offset just past the store.
        program_geometry(3'd7, 1'b1, 13'd16, 13'd16, 13'd16, 13'd16, 1'b0);
        queue_access('{sts_pkg::KIND_WRITE, 12'd0, 12'd15, 12'd15, 12'd15, {32{2'b10}}});
        queue_access('{sts_pkg::KIND_READ,  12'd0, 12'd15, 12'd15, 12'd15, 64'd0});
        queue_access('{sts_pkg::KIND_READ,  12'd1, 12'd0,  12'd0,  12'd0,  64'd0});
        queue_access('{sts_pkg::KIND_READ,  12'd0, 12'd16, 12'd0,  12'd0,  64'd0});
        wait_replies_done();

        // Dimension count zero acts as one dimension, column-major, largest size.
        program_geometry(3'd0, 1'b0, 13'd4096, 13'd0, 13'd0, 13'd0, 1'b0);
        queue_access('{sts_pkg::KIND_WRITE, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                       {32{2'b01}}});
        queue_access('{sts_pkg::KIND_READ,  12'd4095, 12'd4095, 12'd4095, 12'd4095, 64'd0});
        queue_access('{sts_pkg::KIND_READ,  12'd0,    12'd0,    12'd0,    12'd0,    64'd0});
        wait_replies_done();

        // Outer stride saturates at the stride limit.
        program_geometry(3'd4, 1'b1, 13'd4096, 13'd4096, 13'd4096, 13'd1, 1'b0);
        queue_access('{sts_pkg::KIND_READ, 12'd0, 12'd0, 12'd4095, 12'd0, 64'd0});
        queue_access('{sts_pkg::KIND_READ, 12'd1, 12'd0, 12'd0,    12'd0, 64'd0});
        queue_access('{sts_pkg::KIND_READ, 12'd0, 12'd1, 12'd0,    12'd0, 64'd0});
        queue_access('{sts_pkg::KIND_READ, 12'd0, 12'd0, 12'd0,    12'd1, 64'd0});
        wait_replies_done();

        // A dimension of size zero rejects every index along it.
        program_geometry(3'd2, 1'b0, 13'd0, 13'd8191, 13'd5, 13'd5, 1'b0);
        queue_access('{sts_pkg::KIND_READ,  12'd0, 12'd0, 12'd0, 12'd0, 64'd0});
        queue_access('{sts_pkg::KIND_WRITE, 12'd0, 12'd5, 12'd0, 12'd0, '1});
        wait_replies_done();

        // Largest sizes in column-major order, with a write to a spare register.
        program_geometry(3'd3, 1'b0, 13'd8191, 13'd8191, 13'd2, 13'd8191, 1'b1);
        queue_access('{sts_pkg::KIND_WRITE, 12'd4095, 12'd0, 12'd0, 12'd0,
                       64'h8000_0000_0000_0001});
        queue_access('{sts_pkg::KIND_READ,  12'd4095, 12'd0, 12'd0, 12'd0, 64'd0});
        queue_access('{sts_pkg::KIND_READ,  12'd0,    12'd1, 12'd0, 12'd0, 64'd0});

        // Random geometries. Each phase starts only after every result has come back,
        // so the sender pauses at each boundary. Every third phase runs with no idling.
        for (phase = 0; phase < 9; phase++)
        begin
            wait_replies_done();
            back_to_back = (phase % 3 == 1);
            if ($urandom_range(0, 4) == 0)
            begin
                raw_dims = sts_pkg::NDIM_W'($urandom_range(4, 7));
                if (raw_dims == 4)
                    raw_dims = '0;
            end
            else
            begin
                raw_dims = sts_pkg::NDIM_W'($urandom_range(1, 4));
            end
            n = (raw_dims == 0) ? 1 :
                (raw_dims > sts_pkg::DIM_LIMIT) ? sts_pkg::DIM_LIMIT : 32'(raw_dims);
            cap = (n == 1) ? 4096 : (n == 2) ? 64 : (n == 3) ? 16 : 8;
            for (i = 0; i < sts_pkg::REG_DIMS; i++)
            begin
                roll = $urandom_range(0, 19);
                if (i >= n)
                    sizes[i] = sts_pkg::DIM_W'($urandom);
                else if (roll == 0)
                    sizes[i] = sts_pkg::DIM_W'(0);
                else if (roll == 1)
                    sizes[i] = sts_pkg::DIM_W'(4096);
                else if (roll == 2)
                    sizes[i] = sts_pkg::DIM_W'($urandom_range(4097, 8191));
                else
                    sizes[i] = sts_pkg::DIM_W'($urandom_range(1, cap));
            end
            program_geometry(raw_dims, 1'($urandom_range(0, 1)), sizes[0], sizes[1],
                             sizes[2], sizes[3], 1'($urandom_range(0, 1)));
            queue_random_phase(98);
        end

        wait_replies_done();
        repeat (20) @(posedge clk);
        $display("Run covered %0d accesses over %0d geometries (%0d register writes).",
                 accesses_taken, geometry_phases, reg_writes);
        $display("%0d results compared, %0d out of bounds, %0d nonzero reads.",
                 results_checked, oob_seen, nonzero_reads);
        if (err_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d of %0d accesses taken, %0d results outstanding.",
                 accesses_taken, accesses_queued, element_replies_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
